FILE: hw/rtl/rbsa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Row bitmap seat allocator package
// Shared sizes, codes and the token that walks the chain of row cells.
// ---------------------------------------------------------------------------
package rbsa_pkg;

	// Bitmap dimensions
	localparam int MAX_ROWS  = 26;
	localparam int MAX_SLOTS = 9;

	// Field widths
	localparam int ACTION_W   = 2;
	localparam int ROW_W      = 5;
	localparam int SLOT_NUM_W = 5;
	localparam int SEAT_W     = 5;
	localparam int RUN_W      = 4;
	localparam int FREE_W     = 8;
	localparam int GFIRST_W   = 4;
	localparam int ROWS_CFG_W = 5;
	localparam int SPR_W      = 4;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	typedef enum logic [ACTION_W-1:0] {
		ACT_CLAIM   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_RUN     = 2'd2,
		ACT_COUNT   = 2'd3
	} action_t;

	typedef enum logic {
		REG_ROW_COUNT     = 1'b0,
		REG_SLOTS_PER_ROW = 1'b1
	} cfg_reg_t;

	// Request plus partial result, handed from cell to cell
	typedef struct packed {
		logic                valid;
		action_t             action;
		logic [ROW_W-1:0]    row;
		logic [SEAT_W-1:0]   seat;
		logic [RUN_W-1:0]    run_len;
		logic                ok;
		logic [FREE_W-1:0]   free_acc;
		logic [ROW_W-1:0]    grow;
		logic [GFIRST_W-1:0] gfirst;
	} rbsa_token_t;

	// Configuration broadcast to every cell
	typedef struct packed {
		logic                  clear;
		logic [ROWS_CFG_W-1:0] row_count;
		logic [SPR_W-1:0]      slots_per_row;
	} rbsa_cfg_t;

	function automatic logic [SPR_W-1:0] ones_count(input logic [MAX_SLOTS-1:0] v);
		logic [SPR_W-1:0] c;
		c = '0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			c = c + SPR_W'(v[i]);
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/rbsa_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Row cell
// Holds one bitmap row; serves the passing token and hands it on.
// ---------------------------------------------------------------------------
module rbsa_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rbsa_pkg::ROW_W-1:0] cell_row,
	input  rbsa_pkg::rbsa_cfg_t       cfg,
	input  rbsa_pkg::rbsa_token_t     tok_in,
	output rbsa_pkg::rbsa_token_t     tok_out
);
	import rbsa_pkg::*;

	logic [MAX_SLOTS-1:0] occ_q;
	rbsa_token_t          tok_q;

	logic                 active;
	logic                 row_hit;
	logic                 seat_ok;
	logic [MAX_SLOTS-1:0] seat_bit;
	logic [MAX_SLOTS-1:0] span_mask;
	logic [MAX_SLOTS-1:0] run_mask;
	logic [MAX_SLOTS-1:0] win;
	logic [MAX_SLOTS-1:0] fits;
	logic                 run_found;
	logic [GFIRST_W-1:0]  run_first;
	logic [MAX_SLOTS-1:0] occ_next;
	logic [SPR_W-1:0]     row_free;
	rbsa_token_t          tok_next;

	// Decode the token against this row
	always_comb begin
		active  = {1'b0, cell_row} < {1'b0, cfg.row_count};
		row_hit = tok_in.row == cell_row;
		seat_ok = (tok_in.seat != '0) && (tok_in.seat <= SEAT_W'(cfg.slots_per_row));
		for (int i = 0; i < MAX_SLOTS; i++) begin
			seat_bit[i]  = tok_in.seat == SEAT_W'(i + 1);
			span_mask[i] = (SPR_W + 1)'(i) < (SPR_W + 1)'(cfg.slots_per_row);
			run_mask[i]  = (RUN_W + 1)'(i) < (RUN_W + 1)'(tok_in.run_len);
		end
	end

	// Check every start position for a free run, lowest one wins
	always_comb begin
		win       = '0;
		fits      = '0;
		run_found = 1'b0;
		run_first = '0;
		for (int s = 0; s < MAX_SLOTS; s++) begin
			win     = run_mask << s;
			fits[s] = ((6'(tok_in.run_len) + 6'(s)) <= 6'(cfg.slots_per_row))
				&& ((occ_q & win) == '0);
		end
		for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
			if (fits[s]) begin
				run_found = 1'b1;
				run_first = GFIRST_W'(s);
			end
		end
	end

	// Apply the request and add this row's free count
	always_comb begin
		occ_next = occ_q;
		tok_next = tok_in;
		if (tok_in.valid && active) begin
			case (tok_in.action)
				ACT_CLAIM: begin
					if (row_hit && seat_ok && ((occ_q & seat_bit) == '0)) begin
						occ_next    = occ_q | seat_bit;
						tok_next.ok = 1'b1;
					end
				end
				ACT_RELEASE: begin
					if (row_hit && seat_ok && ((occ_q & seat_bit) != '0)) begin
						occ_next    = occ_q & ~seat_bit;
						tok_next.ok = 1'b1;
					end
				end
				ACT_RUN: begin
					if (!tok_in.ok && tok_in.run_len != '0 && run_found) begin
						occ_next        = occ_q | (run_mask << run_first);
						tok_next.ok     = 1'b1;
						tok_next.grow   = cell_row;
						tok_next.gfirst = run_first + GFIRST_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
		row_free = cfg.slots_per_row - ones_count(occ_next & span_mask);
		if (active) begin
			tok_next.free_acc = tok_in.free_acc + FREE_W'(row_free);
		end
	end

	// Hold the row; clear it on a configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cfg.clear) begin
			occ_q <= '0;
		end else if (tok_in.valid) begin
			occ_q <= occ_next;
		end
	end

	// Advance the token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_next;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: hw/rtl/row_bitmap_seat_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Row bitmap seat allocator
// Seat bitmap with single seat claim and release, first fit run claim and
// free count, built as a chain of row cells.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. It enters the first
// row cell at once and moves one row cell per clock, so the done strobe marks
// its result beat once it has passed the last row cell, for every action.
// busy drops in the cycle done is shown, so a new request can be taken at the
// edge that ends it. The result is shown for that one cycle only and is not
// held. A write to either configuration register clears the whole bitmap;
// write only while busy is low.
module row_bitmap_seat_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             start,
	output logic                             busy,
	input  logic [rbsa_pkg::ACTION_W-1:0]    action,
	input  logic [rbsa_pkg::ROW_W-1:0]       row_index,
	input  logic signed [rbsa_pkg::SLOT_NUM_W-1:0] slot_number,
	input  logic [rbsa_pkg::RUN_W-1:0]       run_length,
	// result channel
	output logic                             done,
	output logic                             success,
	output logic [rbsa_pkg::FREE_W-1:0]      free_slots,
	output logic [rbsa_pkg::ROW_W-1:0]       granted_row,
	output logic [rbsa_pkg::GFIRST_W-1:0]    granted_first_slot,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rbsa_pkg::PADDR_W-1:0]     paddr,
	input  logic [rbsa_pkg::PDATA_W-1:0]     pwdata,
	output logic [rbsa_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);
	import rbsa_pkg::*;

	logic [ROWS_CFG_W-1:0] row_count_q;
	logic [SPR_W-1:0]      slots_per_row_q;
	logic                  busy_q;
	logic                  accept;
	logic                  cfg_wr;
	cfg_reg_t              cfg_sel;
	logic [ROWS_CFG_W-1:0] wr_rows;
	logic [SPR_W-1:0]      wr_spr;
	logic [SEAT_W-1:0]     seat;
	rbsa_cfg_t             cfg;
	rbsa_token_t           chain [MAX_ROWS+1];

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_sel = cfg_reg_t'(paddr[2]);
	assign wr_rows = (pwdata[ROWS_CFG_W-1:0] > ROWS_CFG_W'(MAX_ROWS)) ?
		ROWS_CFG_W'(MAX_ROWS) : pwdata[ROWS_CFG_W-1:0];
	assign wr_spr  = (pwdata[SPR_W-1:0] > SPR_W'(MAX_SLOTS)) ?
		SPR_W'(MAX_SLOTS) : pwdata[SPR_W-1:0];

	// Store clamped configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q     <= ROWS_CFG_W'(MAX_ROWS);
			slots_per_row_q <= SPR_W'(MAX_SLOTS);
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_ROW_COUNT:     row_count_q     <= wr_rows;
				REG_SLOTS_PER_ROW: slots_per_row_q <= wr_spr;
				default: begin
				end
			endcase
		end
	end

	// Read back the selected register
	always_comb begin
		unique case (cfg_sel)
			REG_ROW_COUNT:     prdata = PDATA_W'(row_count_q);
			REG_SLOTS_PER_ROW: prdata = PDATA_W'(slots_per_row_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.clear         = cfg_wr;
	assign cfg.row_count     = row_count_q;
	assign cfg.slots_per_row = slots_per_row_q;

	// Track the request in flight
	assign done   = chain[MAX_ROWS].valid;
	assign busy   = busy_q && !done;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// Build the entering token; the seat is the magnitude of slot_number
	assign seat = slot_number[SLOT_NUM_W-1] ? (SEAT_W'(0) - SEAT_W'(slot_number))
		: SEAT_W'(slot_number);

	always_comb begin
		chain[0].valid    = accept;
		chain[0].action   = action_t'(action);
		chain[0].row      = row_index;
		chain[0].seat     = seat;
		chain[0].run_len  = run_length;
		chain[0].ok       = (action_t'(action) == ACT_COUNT)
			|| ((action_t'(action) == ACT_RUN) && (run_length == '0));
		chain[0].free_acc = '0;
		chain[0].grow     = '0;
		chain[0].gfirst   = '0;
	end

	// One cell per row
	for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
		rbsa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_row (ROW_W'(r)),
			.cfg      (cfg),
			.tok_in   (chain[r]),
			.tok_out  (chain[r+1])
		);
	end

	// Drive the result beat from the last cell
	assign success            = chain[MAX_ROWS].ok;
	assign free_slots         = chain[MAX_ROWS].free_acc;
	assign granted_row        = chain[MAX_ROWS].grow;
	assign granted_first_slot = chain[MAX_ROWS].gfirst;

endmodule

FILE: hw/rtl/rbsa_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Allocator port checker
// Watches the request and result ports of the allocator over time.
// ---------------------------------------------------------------------------
module rbsa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic                              success,
	input logic [rbsa_pkg::ROW_W-1:0]        granted_row,
	input logic [rbsa_pkg::GFIRST_W-1:0]     granted_first_slot
);
	import rbsa_pkg::*;

	// One request in flight gives a single-cycle result beat
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// An accepted request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// busy only rises from an accept
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	// A granted run implies success
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (granted_first_slot != '0 || granted_row != '0)) |-> success)
		else $error("grant reported without success");

endmodule

bind row_bitmap_seat_allocator rbsa_checker u_rbsa_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.start              (start),
	.busy               (busy),
	.done               (done),
	.success            (success),
	.granted_row        (granted_row),
	.granted_first_slot (granted_first_slot)
);

FILE: tb/sv/rbsa_seat_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Seat allocator checker
// Watches the request, result and register ports of the seat allocator,
// keeps its own copy of the seat bitmap and the hall size, predicts every
// result beat when its request is taken and compares it, in order, with the
// beat the block shows.
// ---------------------------------------------------------------------------
module rbsa_seat_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic [rbsa_pkg::ACTION_W-1:0]          action,
	input  logic [rbsa_pkg::ROW_W-1:0]             row_index,
	input  logic signed [rbsa_pkg::SLOT_NUM_W-1:0] slot_number,
	input  logic [rbsa_pkg::RUN_W-1:0]             run_length,
	input  logic                                   done,
	input  logic                                   success,
	input  logic [rbsa_pkg::FREE_W-1:0]            free_slots,
	input  logic [rbsa_pkg::ROW_W-1:0]             granted_row,
	input  logic [rbsa_pkg::GFIRST_W-1:0]          granted_first_slot,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [rbsa_pkg::PADDR_W-1:0]           paddr,
	input  logic [rbsa_pkg::PDATA_W-1:0]           pwdata,
	input  logic                                   pready,
	output int                                     pending,
	output int                                     errors
);
	import rbsa_pkg::*;

	typedef struct packed {
		logic                ok;
		logic [FREE_W-1:0]   free;
		logic [ROW_W-1:0]    grow;
		logic [GFIRST_W-1:0] gfirst;
	} seat_result_t;

	logic [MAX_SLOTS-1:0] seat_map [MAX_ROWS];
	int unsigned          rows_in_use;
	int unsigned          seats_in_use;
	seat_result_t         outcome_q [$];
	int                   fail_count;

	// Free seats inside the area in use
	function automatic int unsigned free_seats();
		int unsigned total;
		total = 0;
		for (int r = 0; r < MAX_ROWS; r++) begin
			for (int s = 0; s < MAX_SLOTS; s++) begin
				if (r < rows_in_use && s < seats_in_use && !seat_map[r][s])
					total++;
			end
		end
		return total;
	endfunction

	// Apply one request to the bitmap and return the beat it should produce
	function automatic seat_result_t allocate(input action_t act,
			input logic [ROW_W-1:0] row, input logic [SLOT_NUM_W-1:0] slot_raw,
			input logic [RUN_W-1:0] run_len);
		seat_result_t res;
		int unsigned  seat;
		int unsigned  run;
		bit           found;
		res = '0;
		found = 1'b0;
		// negative seat numbers count by magnitude
		seat = slot_raw[SLOT_NUM_W-1] ? 32 - int'(slot_raw) : int'(slot_raw);
		case (act)
			ACT_CLAIM, ACT_RELEASE: begin
				if (row < rows_in_use && seat >= 1 && seat <= seats_in_use) begin
					if (act == ACT_CLAIM && !seat_map[row][seat-1]) begin
						seat_map[row][seat-1] = 1'b1;
						res.ok = 1'b1;
					end else if (act == ACT_RELEASE && seat_map[row][seat-1]) begin
						seat_map[row][seat-1] = 1'b0;
						res.ok = 1'b1;
					end
				end
			end
			ACT_RUN: begin
				if (run_len == 0) begin
					res.ok = 1'b1;
				end else if (run_len <= seats_in_use) begin
					// first fit: rows in order, lowest seat first
					for (int r = 0; r < MAX_ROWS; r++) begin
						run = 0;
						for (int s = 0; s < MAX_SLOTS; s++) begin
							if (!found && r < rows_in_use && s < seats_in_use) begin
								if (seat_map[r][s]) begin
									run = 0;
								end else begin
									run++;
									if (run == run_len) begin
										for (int b = 0; b < MAX_SLOTS; b++) begin
											if (b <= s && b > s - int'(run_len))
												seat_map[r][b] = 1'b1;
										end
										res.grow   = ROW_W'(r);
										res.gfirst = GFIRST_W'(s + 2 - int'(run_len));
										res.ok     = 1'b1;
										found      = 1'b1;
									end
								end
							end
						end
					end
				end
			end
			default: begin
				res.ok = 1'b1;
			end
		endcase
		res.free = FREE_W'(free_seats());
		return res;
	endfunction

	function automatic void report_fail(input string what, input seat_result_t want,
			input seat_result_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t %s: expected ok=%0d free=%0d row=%0d first=%0d,", $realtime, what,
				want.ok, want.free, want.grow, want.gfirst,
				" got ok=%0d free=%0d row=%0d first=%0d",
				got.ok, got.free, got.grow, got.gfirst);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		seat_result_t got;
		seat_result_t want;
		logic [4:0]   value;
		if (!arst_n) begin
			rows_in_use  = MAX_ROWS;
			seats_in_use = MAX_SLOTS;
			foreach (seat_map[r]) seat_map[r] = '0;
			outcome_q.delete();
			fail_count = 0;
			pending <= 0;
			errors  <= 0;
		end else begin
			// check the result beat shown in the cycle that just ended
			if (done) begin
				got = {success, free_slots, granted_row, granted_first_slot};
				if (outcome_q.size() == 0) begin
					report_fail("result beat with no request outstanding", '0, got);
				end else begin
					want = outcome_q.pop_front();
					if (got.ok !== want.ok || got.free !== want.free ||
							got.grow !== want.grow || got.gfirst !== want.gfirst)
						report_fail("result mismatch", want, got);
				end
			end
			// predict the request beat taken at this edge
			if (start && !busy)
				outcome_q.push_back(allocate(action_t'(action), row_index, slot_number,
					run_length));
			// track register writes; either one clears the hall
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				value = pwdata[4:0];
				case (cfg_reg_t'(paddr[2]))
					REG_ROW_COUNT: begin
						rows_in_use = (value > MAX_ROWS) ? MAX_ROWS : value;
					end
					default: begin
						seats_in_use = (value[3:0] > MAX_SLOTS) ? MAX_SLOTS : value[3:0];
					end
				endcase
				foreach (seat_map[r]) seat_map[r] = '0;
			end
			pending <= outcome_q.size();
			errors  <= fail_count;
		end
	end

endmodule

FILE: tb/sv/tb_row_bitmap_seat_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Seat allocator testbench
// Drives claim, release, run claim and count requests, a directed list then
// random bursts over a series of hall sizes set through the register port,
// and leaves prediction and comparison of every result beat to the checker.
// ---------------------------------------------------------------------------
module tb_row_bitmap_seat_allocator;
	import rbsa_pkg::*;

	localparam int PHASES     = 9;
	localparam int PER_PHASE  = 95;
	localparam int SETTLE     = 32;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	logic                           busy;
	logic [ACTION_W-1:0]            action = '0;
	logic [ROW_W-1:0]               row_index = '0;
	logic signed [SLOT_NUM_W-1:0]   slot_number = '0;
	logic [RUN_W-1:0]               run_length = '0;
	logic                           done;
	logic                           success;
	logic [FREE_W-1:0]              free_slots;
	logic [ROW_W-1:0]               granted_row;
	logic [GFIRST_W-1:0]            granted_first_slot;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [PADDR_W-1:0]             paddr = '0;
	logic [PDATA_W-1:0]             pwdata = '0;
	logic [PDATA_W-1:0]             prdata;
	logic                           pready;
	int                             pending;
	int                             errors;

	// hall size as currently programmed, after clamping
	int unsigned rows_now = MAX_ROWS;
	int unsigned seats_now = MAX_SLOTS;
	int          burst_left = 0;

	logic [4:0] hall_rows  [PHASES] = '{5'd1, 5'd31, 5'd0, 5'd26, 5'd2, 5'd5, 5'd26, 5'd13, 5'd20};
	logic [3:0] hall_seats [PHASES] = '{4'd1, 4'd15, 4'd7, 4'd0, 4'd9, 4'd3, 4'd9, 4'd10, 4'd6};

	row_bitmap_seat_allocator dut (.*);

	rbsa_seat_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Hold one request beat until the block takes it
	task automatic send_request(input action_t act, input logic [ROW_W-1:0] row,
			input logic [SLOT_NUM_W-1:0] slot, input logic [RUN_W-1:0] k);
		start       <= 1'b1;
		action      <= act;
		row_index   <= row;
		slot_number <= slot;
		run_length  <= k;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Open a random gap at the start of each burst
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// Drop start and wait until every result beat has come back
	task automatic drain();
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [4:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * int'(idx));
		pwdata  <= ($urandom & 32'hFFFF_FFE0) | 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly well-formed requests inside the hall, some out of range
	task automatic random_request();
		action_t          act;
		logic [ROW_W-1:0] row;
		logic [4:0]       slot;
		logic [RUN_W-1:0] k;
		int               pick;
		pick = $urandom_range(0, 99);
		act = (pick < 40) ? ACT_CLAIM : (pick < 65) ? ACT_RELEASE :
			(pick < 88) ? ACT_RUN : ACT_COUNT;
		if (rows_now > 0 && $urandom_range(0, 9) != 0)
			row = ROW_W'($urandom_range(0, rows_now - 1));
		else
			row = ROW_W'($urandom);
		if (seats_now > 0 && $urandom_range(0, 9) != 0) begin
			slot = 5'($urandom_range(1, seats_now));
			if ($urandom_range(0, 1))
				slot = -slot;
		end else begin
			slot = 5'($urandom);
		end
		if ($urandom_range(0, 5) != 0)
			k = RUN_W'($urandom_range(0, seats_now));
		else
			k = RUN_W'($urandom);
		pace();
		send_request(act, row, slot, k);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single seats: claim, double claim, release by magnitude, double release
		send_request(ACT_CLAIM,   5'd0,  5'd1,   4'd0);
		send_request(ACT_CLAIM,   5'd0,  5'd1,   4'd0);
		send_request(ACT_RELEASE, 5'd0,  -5'sd1, 4'd0);
		send_request(ACT_RELEASE, 5'd0,  5'd1,   4'd0);
		// seat zero, last seat, seats past the row, most negative seat
		send_request(ACT_CLAIM,   5'd0,  5'd0,   4'd0);
		send_request(ACT_CLAIM,   5'd25, 5'd9,   4'd0);
		send_request(ACT_CLAIM,   5'd25, -5'sd9, 4'd0);
		send_request(ACT_CLAIM,   5'd0,  5'd10,  4'd0);
		send_request(ACT_CLAIM,   5'd0,  5'b10000, 4'd15);
		send_request(ACT_CLAIM,   5'd0,  5'd15,  4'd0);
		// rows past the hall
		send_request(ACT_CLAIM,   5'd26, 5'd1,   4'd0);
		send_request(ACT_RELEASE, 5'd31, 5'd1,   4'd0);
		// runs: empty, full row, too long
		send_request(ACT_RUN,     5'd0,  5'd0,   4'd0);
		send_request(ACT_RUN,     5'd0,  5'd0,   4'd9);
		send_request(ACT_RUN,     5'd0,  5'd0,   4'd10);
		send_request(ACT_RUN,     5'd31, 5'd0,   4'd15);
		// runs that skip taken seats and rows
		send_request(ACT_RUN,     5'd0,  5'd0,   4'd1);
		send_request(ACT_CLAIM,   5'd1,  5'd3,   4'd0);
		send_request(ACT_RUN,     5'd0,  5'd0,   4'd2);
		send_request(ACT_COUNT,   5'd31, 5'd31,  4'd15);
		send_request(ACT_RELEASE, 5'd0,  5'd5,   4'd0);
		send_request(ACT_RUN,     5'd0,  5'd0,   4'd1);
		send_request(ACT_COUNT,   5'd0,  5'd0,   4'd0);
		send_request(ACT_CLAIM,   5'd3,  -5'sd15, 4'd7);

		repeat (PER_PHASE - 24) random_request();
		drain();

		// walk the hall sizes, extremes included
		for (int p = 0; p < PHASES; p++) begin
			write_register(REG_ROW_COUNT, hall_rows[p]);
			write_register(REG_SLOTS_PER_ROW, {1'($urandom), hall_seats[p]});
			rows_now  = (hall_rows[p] > MAX_ROWS) ? MAX_ROWS : hall_rows[p];
			seats_now = (hall_seats[p] > MAX_SLOTS) ? MAX_SLOTS : hall_seats[p];
			burst_left = 0;
			repeat (PER_PHASE) random_request();
			drain();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: row_bitmap_seat_allocator.f
hw/rtl/rbsa_pkg.sv
hw/rtl/rbsa_cell.sv
hw/rtl/row_bitmap_seat_allocator.sv
hw/rtl/rbsa_checker.sv
tb/sv/rbsa_seat_checker.sv
tb/sv/tb_row_bitmap_seat_allocator.sv
